>>> design/smik_pkg.sv
// ============================================================================
// smik_pkg: shared types and constants for the swerve module kinematics
// Holds the controller states, register indexes, angle constants and the
// CORDIC arctangent table.
// ============================================================================
package smik_pkg;

    // Number of CORDIC micro-rotations, between 8 and 32.
    localparam int CORDIC_STEPS = 16;

    // Angles in 1/128 degree.
    localparam int FULL_TURN    = 46080;
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_BODY_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_SCALE = 8'd1;

    localparam logic [30:0] BODY_LENGTH_RESET = 31'd32768;
    localparam logic [30:0] SPEED_SCALE_RESET = 31'd65536;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEVER,
        S_VY,
        S_SQ,
        S_START,
        S_RUN,
        S_OPT,
        S_REMS,
        S_REM2,
        S_SPD,
        S_FIN
    } t_state;

    // atan(2^-i) in degrees, scaled by 65536.
    function automatic logic [21:0] atan_lut(input logic [4:0] idx);
        logic [21:0] val;
        unique case (idx)
            5'd0:  val = 22'd2949120;
            5'd1:  val = 22'd1740967;
            5'd2:  val = 22'd919879;
            5'd3:  val = 22'd466945;
            5'd4:  val = 22'd234379;
            5'd5:  val = 22'd117304;
            5'd6:  val = 22'd58666;
            5'd7:  val = 22'd29335;
            5'd8:  val = 22'd14668;
            5'd9:  val = 22'd7334;
            5'd10: val = 22'd3667;
            5'd11: val = 22'd1833;
            5'd12: val = 22'd917;
            5'd13: val = 22'd458;
            5'd14: val = 22'd229;
            5'd15: val = 22'd115;
            5'd16: val = 22'd57;
            5'd17: val = 22'd29;
            5'd18: val = 22'd14;
            5'd19: val = 22'd7;
            5'd20: val = 22'd4;
            5'd21: val = 22'd2;
            5'd22: val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

endpackage

>>> design/swerve_module_inverse_kinematics.sv
// ============================================================================
// swerve_module_inverse_kinematics: wheel heading, steering and speed
// Forms the wheel vector from a drive command, finds its heading and length,
// optimizes the steering angle and direction, and scales the wheel speed.
// ============================================================================
//  Channel  | Handshake                 | Payload
//  command  | i_in_valid / o_in_ready   | i_fwd_vel, i_side_vel, i_turn_rate
//  result   | o_out_valid / i_out_ready | o_steer_angle, o_drive_reversed,
//           |                           | o_wheel_speed
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A command makes one bit-serial pass, and a second one when the heading
// request changes: the first runs the remainder, square root and CORDIC
// side by side, the second reduces the updated angle by a full turn. One
// command is in work at a time; the next one is taken as soon as its result
// sits in the output register, even if that result is still stalled. Reset
// is synchronous and active low.
module swerve_module_inverse_kinematics (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_fwd_vel,
    input  logic signed [31:0] i_side_vel,
    input  logic signed [31:0] i_turn_rate,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_steer_angle,
    output logic               o_drive_reversed,
    output logic signed [31:0] o_wheel_speed,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [smik_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    smik_pkg::t_state r_state, n_state;

    logic [30:0]        r_body_len, r_spd_scale;
    logic signed [31:0] r_u, r_v, r_r;
    logic signed [63:0] r_lever;
    logic signed [31:0] r_vy;
    logic [63:0]        r_sqx, r_sqy;
    logic [62:0]        r_spd_prod;
    logic signed [16:0] r_cal;
    logic signed [31:0] r_angle;
    logic               r_drive;
    logic signed [16:0] r_last_req, r_last_unw, r_last_head;
    logic               r_out_valid;
    logic signed [31:0] r_out_angle, r_out_speed;
    logic               r_out_rev;

    logic               unit_start, rem_start;
    logic               cordic_busy, rem_busy, sqrt_busy;
    logic signed [16:0] heading, rem;
    logic [31:0]        root;
    logic               load_out;

    logic signed [47:0] lever_sh;
    logic signed [48:0] vy_diff;
    logic signed [31:0] vy_sat;
    logic [31:0]        ax, ay;

    logic               zero_vec;
    logic signed [16:0] req;
    logic signed [19:0] cal, dcal, dmag, delta;
    logic               flip;
    logic signed [32:0] ang_sum;
    logic signed [31:0] ang_sat;
    logic [47:0]        spd_rnd;
    logic [31:0]        spd_mag;

    // ------------------------------------------------------------------
    // Serial units
    // ------------------------------------------------------------------
    smik_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (unit_start),
        .i_vx      (r_v),
        .i_vy      (r_vy),
        .o_busy    (cordic_busy),
        .o_heading (heading)
    );

    smik_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_angle (r_angle),
        .o_busy  (rem_busy),
        .o_rem   (rem)
    );

    smik_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (unit_start),
        .i_radicand (r_sqx + r_sqy),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

    // ------------------------------------------------------------------
    // Datapath arithmetic
    // ------------------------------------------------------------------
    always_comb begin
        lever_sh = 48'((r_lever + 64'sd32768) >>> 16);
        vy_diff  = {{17{r_u[31]}}, r_u} - {lever_sh[47], lever_sh};
        if (vy_diff > 49'sd2147483647) begin
            vy_sat = 32'sh7FFFFFFF;
        end else if (vy_diff < -49'sd2147483648) begin
            vy_sat = 32'sh80000000;
        end else begin
            vy_sat = vy_diff[31:0];
        end
        ax = r_v[31] ? 32'(-r_v) : 32'(r_v);
        ay = r_vy[31] ? 32'(-r_vy) : 32'(r_vy);
    end

    always_comb begin
        zero_vec = (r_v == '0) && (r_vy == '0);
        req      = zero_vec ? r_last_head : heading;

        // Put the request on the same side of zero as the module angle.
        cal = 20'(req);
        if (!r_angle[31] && req < 0) begin
            cal = cal + 20'(smik_pkg::FULL_TURN);
        end else if (r_angle[31] && req > 0) begin
            cal = cal - 20'(smik_pkg::FULL_TURN);
        end

        dcal = cal - 20'(r_last_unw);
        if (dcal > 20'(smik_pkg::HALF_TURN)) begin
            dcal = dcal - 20'(smik_pkg::FULL_TURN);
        end else if (dcal < -20'(smik_pkg::HALF_TURN)) begin
            dcal = dcal + 20'(smik_pkg::FULL_TURN);
        end
        dmag = dcal[19] ? -dcal : dcal;
        flip = (dmag > 20'(smik_pkg::QUARTER_TURN)) && (dmag <= 20'(smik_pkg::HALF_TURN));

        delta = cal - 20'(rem);
        if (delta > 20'(smik_pkg::HALF_TURN)) begin
            delta = delta - 20'(smik_pkg::FULL_TURN);
        end else if (delta < -20'(smik_pkg::HALF_TURN)) begin
            delta = delta + 20'(smik_pkg::FULL_TURN);
        end
        // Never turn more than a quarter; the drive reverses instead.
        if (delta > 20'(smik_pkg::QUARTER_TURN) && delta <= 20'(smik_pkg::HALF_TURN)) begin
            delta = delta - 20'(smik_pkg::HALF_TURN);
        end else if (delta < -20'(smik_pkg::QUARTER_TURN)
                     && delta >= -20'(smik_pkg::HALF_TURN)) begin
            delta = delta + 20'(smik_pkg::HALF_TURN);
        end

        ang_sum = 33'(r_angle) + 33'(delta);
        if (ang_sum > 33'sd2147483647) begin
            ang_sat = 32'sh7FFFFFFF;
        end else if (ang_sum < -33'sd2147483648) begin
            ang_sat = 32'sh80000000;
        end else begin
            ang_sat = ang_sum[31:0];
        end
    end

    always_comb begin
        spd_rnd = 48'((64'(r_spd_prod) + 64'd32768) >> 16);
        if (spd_rnd > 48'd2147483647) begin
            spd_mag = 32'h7FFFFFFF;
        end else begin
            spd_mag = spd_rnd[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        unit_start = 1'b0;
        rem_start  = 1'b0;
        load_out   = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            smik_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = smik_pkg::S_LEVER;
                end
            end
            smik_pkg::S_LEVER: n_state = smik_pkg::S_VY;
            smik_pkg::S_VY:    n_state = smik_pkg::S_SQ;
            smik_pkg::S_SQ:    n_state = smik_pkg::S_START;
            smik_pkg::S_START: begin
                unit_start = 1'b1;
                rem_start  = 1'b1;
                n_state    = smik_pkg::S_RUN;
            end
            smik_pkg::S_RUN: begin
                if (!cordic_busy && !rem_busy && !sqrt_busy) begin
                    n_state = smik_pkg::S_OPT;
                end
            end
            smik_pkg::S_OPT: begin
                n_state = (req != r_last_req) ? smik_pkg::S_REMS : smik_pkg::S_SPD;
            end
            smik_pkg::S_REMS: begin
                rem_start = 1'b1;
                n_state   = smik_pkg::S_REM2;
            end
            smik_pkg::S_REM2: begin
                if (!rem_busy) begin
                    n_state = smik_pkg::S_SPD;
                end
            end
            smik_pkg::S_SPD: n_state = smik_pkg::S_FIN;
            smik_pkg::S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = smik_pkg::S_IDLE;
                end
            end
            default: n_state = smik_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smik_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_len  <= smik_pkg::BODY_LENGTH_RESET;
            r_spd_scale <= smik_pkg::SPEED_SCALE_RESET;
            r_angle     <= '0;
            r_drive     <= 1'b0;
            r_last_req  <= '0;
            r_last_unw  <= '0;
            r_last_head <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == smik_pkg::CFG_BODY_LENGTH) begin
                    r_body_len <= i_cfg_data[30:0];
                end else if (i_cfg_index == smik_pkg::CFG_SPEED_SCALE) begin
                    r_spd_scale <= i_cfg_data[30:0];
                end
            end

            if (r_state == smik_pkg::S_OPT) begin
                if (!zero_vec) begin
                    r_last_head <= heading;
                end
                if (req != r_last_req) begin
                    r_drive    <= r_drive ^ flip;
                    r_last_req <= req;
                    r_last_unw <= cal[16:0];
                    r_angle    <= ang_sat;
                end
            end

            // Aligned with the request: drive forward again.
            if (r_state == smik_pkg::S_REM2 && !rem_busy && r_cal == rem) begin
                r_drive <= 1'b0;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == smik_pkg::S_IDLE && i_in_valid) begin
            r_u <= i_fwd_vel;
            r_v <= i_side_vel;
            r_r <= i_turn_rate;
        end
        if (r_state == smik_pkg::S_LEVER) begin
            r_lever <= 64'($signed({1'b0, r_body_len})) * 64'(r_r);
        end
        if (r_state == smik_pkg::S_VY) begin
            r_vy <= vy_sat;
        end
        if (r_state == smik_pkg::S_SQ) begin
            r_sqx <= 64'(ax) * 64'(ax);
            r_sqy <= 64'(ay) * 64'(ay);
        end
        if (r_state == smik_pkg::S_OPT) begin
            r_cal <= cal[16:0];
        end
        if (r_state == smik_pkg::S_SPD) begin
            r_spd_prod <= 63'(r_spd_scale) * 63'(root);
        end
        if (load_out) begin
            r_out_angle <= r_angle;
            r_out_rev   <= r_drive;
            r_out_speed <= r_drive ? -$signed(spd_mag) : $signed(spd_mag);
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_steer_angle    = r_out_angle;
    assign o_drive_reversed = r_out_rev;
    assign o_wheel_speed    = r_out_speed;

endmodule

>>> design/smik_cordic.sv
// ============================================================================
// smik_cordic: iterative vectoring CORDIC for the wheel heading
// One micro-rotation per cycle; gives atan2(vy, vx) in 1/128 degree.
// ============================================================================
module smik_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_vx,
    input  logic signed [31:0] i_vy,
    output logic               o_busy,
    output logic signed [16:0] o_heading
);

    logic signed [51:0] r_x, r_y;
    logic signed [25:0] r_ang;
    logic [5:0]         r_step;
    logic               r_busy;

    logic signed [51:0] x0, y0, xi, yi, xs, ys;
    logic signed [25:0] ang0, rnd;
    logic signed [25:0] atan_v;

    always_comb begin
        x0 = {{4{i_vx[31]}}, i_vx, 16'd0};
        y0 = {{4{i_vy[31]}}, i_vy, 16'd0};
        xi = x0;
        yi = y0;
        ang0 = '0;
        // Vectors in the left half plane are turned by a quarter first.
        if (x0 < 0) begin
            if (y0 >= 0) begin
                xi = y0;
                yi = -x0;
                ang0 = 26'sd5898240;
            end else begin
                xi = -y0;
                yi = x0;
                ang0 = -26'sd5898240;
            end
        end
    end

    assign xs     = r_x >>> r_step[4:0];
    assign ys     = r_y >>> r_step[4:0];
    assign atan_v = $signed({4'd0, smik_pkg::atan_lut(r_step[4:0])});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (r_step == 6'(smik_pkg::CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= xi;
            r_y   <= yi;
            r_ang <= ang0;
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x   <= r_x + ys;
                r_y   <= r_y - xs;
                r_ang <= r_ang + atan_v;
            end else begin
                r_x   <= r_x - ys;
                r_y   <= r_y + xs;
                r_ang <= r_ang - atan_v;
            end
        end
    end

    always_comb begin
        rnd = (r_ang + 26'sd256) >>> 9;
        if (rnd > 26'(smik_pkg::HALF_TURN)) begin
            o_heading = 17'(smik_pkg::HALF_TURN);
        end else if (rnd < -26'(smik_pkg::HALF_TURN)) begin
            o_heading = -17'(smik_pkg::HALF_TURN);
        end else begin
            o_heading = rnd[16:0];
        end
    end

    assign o_busy = r_busy;

endmodule

>>> design/smik_rem.sv
// ============================================================================
// smik_rem: bit-serial remainder of the module angle by a full turn
// Restoring division, one dividend bit per cycle; the remainder takes the
// sign of the angle.
// ============================================================================
module smik_rem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_angle,
    output logic               o_busy,
    output logic signed [16:0] o_rem
);

    logic [31:0] r_dvd;
    logic [15:0] r_part;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic        r_busy;

    logic [16:0] trial;
    logic [15:0] n_part;

    always_comb begin
        trial = {r_part, r_dvd[31]};
        if (trial >= 17'(smik_pkg::FULL_TURN)) begin
            n_part = 16'(trial - 17'(smik_pkg::FULL_TURN));
        end else begin
            n_part = trial[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_angle[31] ? 32'(-i_angle) : 32'(i_angle);
            r_neg  <= i_angle[31];
            r_part <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[30:0], 1'b0};
            r_part <= n_part;
        end
    end

    assign o_rem  = r_neg ? -$signed({1'b0, r_part}) : $signed({1'b0, r_part});
    assign o_busy = r_busy;

endmodule

>>> design/smik_isqrt.sv
// ============================================================================
// smik_isqrt: digit-serial integer square root
// Two radicand bits per cycle, one root bit per cycle, floor result.
// ============================================================================
module smik_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_busy,
    output logic [31:0] o_root
);

    logic [63:0] r_n;
    logic [33:0] r_r;
    logic [31:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;

    logic [35:0] cur, trial;

    assign cur   = {r_r, r_n[63:62]};
    assign trial = {2'b00, r_q, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= i_radicand;
            r_r <= '0;
            r_q <= '0;
        end else if (r_busy) begin
            r_n <= {r_n[61:0], 2'b00};
            if (cur >= trial) begin
                r_r <= 34'(cur - trial);
                r_q <= {r_q[30:0], 1'b1};
            end else begin
                r_r <= cur[33:0];
                r_q <= {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_root = r_q;
    assign o_busy = r_busy;

endmodule
